FILE: src/spi_page_program_sequencer_defines.svh
// ============================================================================
// SPI page program sequencer - assertion macros
// Shared property wrappers for the port-level checker.
// ============================================================================
`ifndef SPI_PAGE_PROGRAM_SEQUENCER_DEFINES_SVH
`define SPI_PAGE_PROGRAM_SEQUENCER_DEFINES_SVH

// Property checked outside reset only
`define SPP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included
`define SPP_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/spp_pkg.sv
// ============================================================================
// SPI page program sequencer - package
// Types, opcodes and word layouts shared by the front end, queue and back end.
// ============================================================================
package spp_pkg;

    // Input word kinds (tuser)
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_STATUS = 2'd2;

    // Flash opcodes and bytes
    localparam logic [7:0] OP_WREN    = 8'h06;
    localparam logic [7:0] OP_RDSR    = 8'h05;
    localparam logic [7:0] OP_PP      = 8'h02;
    localparam logic [7:0] DUMMY_BYTE = 8'hff;
    localparam int unsigned BUSY_BIT  = 0;

    // Full 24-bit address space
    localparam logic [24:0] ADDR_SPACE = 25'h100_0000;

    // Configuration register indexes
    localparam logic [1:0] REG_DEVICE_SIZE      = 2'd0;
    localparam logic [1:0] REG_PROTECT_BOUNDARY = 2'd1;
    localparam logic [1:0] REG_POLL_LIMIT       = 2'd2;

    localparam logic [24:0] DEVICE_SIZE_RST      = 25'd2097152;
    localparam logic [23:0] PROTECT_BOUNDARY_RST = 24'd1048576;
    localparam logic [16:0] POLL_LIMIT_RST       = 17'd100000;

    // Port widths
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 25;

    // Input tdata field offsets
    localparam int unsigned IN_ADDR_LSB   = 0;
    localparam int unsigned IN_COUNT_LSB  = 24;
    localparam int unsigned IN_ALLOW_BIT  = 49;
    localparam int unsigned IN_DATA_LSB   = 50;
    localparam int unsigned IN_STATUS_LSB = 58;

    // Job queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;

    typedef struct packed {
        logic [24:0] device_size;
        logic [23:0] protect_boundary;
        logic [16:0] poll_limit;
    } cfg_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_POLL = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        JOB_FINISH   = 3'd0,
        JOB_POLL     = 3'd1,
        JOB_CHUNK    = 3'd2,
        JOB_DATA     = 3'd3,
        JOB_DATA_END = 3'd4
    } job_kind_t;

    // One queued job: expands into one to five output words
    typedef struct packed {
        job_kind_t   kind;
        logic        ok;
        logic [23:0] address;
        logic [7:0]  data;
    } job_t;

    // Output word, tx_byte in the lowest bits
    typedef struct packed {
        logic       success;
        logic       finished;
        logic       expect_status;
        logic       frame_end;
        logic       tx_valid;
        logic [7:0] tx_byte;
    } result_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic empty;
        job_t head;
    } q_head_t;

endpackage

FILE: src/spp_front.sv
// ============================================================================
// SPI page program sequencer - front end
// Accepts input words, tracks the write state and queues at most one job per word.
// ============================================================================
module spp_front #(
    parameter int unsigned PAGE_BYTES = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [spp_pkg::IN_TDATA_W-1:0] in_data,
    input  logic [spp_pkg::IN_TUSER_W-1:0] in_user,
    input  spp_pkg::cfg_t                  cfg,
    input  logic                           q_full,
    output logic                           push,
    output spp_pkg::job_t                  push_job
);
    import spp_pkg::*;

    // PAGE_BYTES is a power of two
    localparam int unsigned OFS_W   = $clog2(PAGE_BYTES);
    localparam int unsigned CHUNK_W = OFS_W + 1;

    phase_t             phase_reg, phase_next;
    logic [23:0]        cur_address_reg, cur_address_next;
    logic [24:0]        bytes_left_reg, bytes_left_next;
    logic [CHUNK_W-1:0] chunk_left_reg, chunk_left_next;
    logic [16:0]        poll_count_reg, poll_count_next;
    logic               final_wait_reg, final_wait_next;

    logic               accept;
    logic [23:0]        addr;
    logic [24:0]        count;
    logic               allow;
    logic [7:0]         data_byte;
    logic [7:0]         status_byte;
    logic [24:0]        size_clamped;
    logic [25:0]        end_sum;
    logic               out_of_range;
    logic [CHUNK_W-1:0] room;
    logic [CHUNK_W-1:0] chunk_sel;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // Field unpacking
    assign addr        = in_data[IN_ADDR_LSB +: 24];
    assign count       = in_data[IN_COUNT_LSB +: 25];
    assign allow       = in_data[IN_ALLOW_BIT];
    assign data_byte   = in_data[IN_DATA_LSB +: 8];
    assign status_byte = in_data[IN_STATUS_LSB +: 8];

    // Range check against the clamped device size
    assign size_clamped = (cfg.device_size > ADDR_SPACE) ? ADDR_SPACE : cfg.device_size;
    assign end_sum      = {2'b00, addr} + {1'b0, count};
    assign out_of_range = end_sum > {1'b0, size_clamped};

    // Bytes to the next page boundary, capped by what is left
    assign room      = CHUNK_W'(PAGE_BYTES) - {1'b0, cur_address_reg[OFS_W-1:0]};
    assign chunk_sel = ({{(25-CHUNK_W){1'b0}}, room} < bytes_left_reg)
                       ? room : bytes_left_reg[CHUNK_W-1:0];

    // Next state and job
    always_comb
    begin
        phase_next       = phase_reg;
        cur_address_next = cur_address_reg;
        bytes_left_next  = bytes_left_reg;
        chunk_left_next  = chunk_left_reg;
        poll_count_next  = poll_count_reg;
        final_wait_next  = final_wait_reg;
        push             = 1'b0;
        push_job.kind    = JOB_FINISH;
        push_job.ok      = 1'b0;
        push_job.address = cur_address_reg;
        push_job.data    = data_byte;

        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (in_user == CMD_START)
                    begin
                        push = 1'b1;
                        if (count == 25'd0)
                        begin
                            push_job.ok = 1'b1;
                        end
                        else if (out_of_range || (!allow && addr < cfg.protect_boundary))
                        begin
                            push_job.ok = 1'b0;
                        end
                        else
                        begin
                            push_job.kind    = JOB_POLL;
                            cur_address_next = addr;
                            bytes_left_next  = count;
                            final_wait_next  = 1'b0;
                            poll_count_next  = 17'd1;
                            phase_next       = PH_POLL;
                        end
                    end
                end
                PH_POLL:
                begin
                    if (in_user == CMD_STATUS)
                    begin
                        push = 1'b1;
                        if (!status_byte[BUSY_BIT])
                        begin
                            if (final_wait_reg)
                            begin
                                push_job.ok      = 1'b1;
                                phase_next       = PH_IDLE;
                                final_wait_next  = 1'b0;
                                chunk_left_next  = '0;
                                bytes_left_next  = '0;
                                poll_count_next  = '0;
                            end
                            else
                            begin
                                push_job.kind   = JOB_CHUNK;
                                chunk_left_next = chunk_sel;
                                poll_count_next = '0;
                                phase_next      = PH_DATA;
                            end
                        end
                        else if (poll_count_reg >= cfg.poll_limit)
                        begin
                            push_job.ok     = 1'b0;
                            phase_next      = PH_IDLE;
                            final_wait_next = 1'b0;
                            chunk_left_next = '0;
                            bytes_left_next = '0;
                            poll_count_next = '0;
                        end
                        else
                        begin
                            push_job.kind   = JOB_POLL;
                            poll_count_next = poll_count_reg + 17'd1;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (in_user == CMD_DATA)
                    begin
                        push             = 1'b1;
                        chunk_left_next  = chunk_left_reg - CHUNK_W'(1);
                        bytes_left_next  = bytes_left_reg - 25'd1;
                        cur_address_next = cur_address_reg + 24'd1;
                        if (chunk_left_reg == CHUNK_W'(1))
                        begin
                            // Last byte of the chunk: close frame and poll
                            push_job.kind   = JOB_DATA_END;
                            final_wait_next = (bytes_left_reg == 25'd1);
                            poll_count_next = 17'd1;
                            phase_next      = PH_POLL;
                        end
                        else
                        begin
                            push_job.kind = JOB_DATA;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            cur_address_reg <= '0;
            bytes_left_reg  <= '0;
            chunk_left_reg  <= '0;
            poll_count_reg  <= '0;
            final_wait_reg  <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            cur_address_reg <= cur_address_next;
            bytes_left_reg  <= bytes_left_next;
            chunk_left_reg  <= chunk_left_next;
            poll_count_reg  <= poll_count_next;
            final_wait_reg  <= final_wait_next;
        end
    end

endmodule

FILE: src/spp_queue.sv
// ============================================================================
// SPI page program sequencer - job queue
// Small register queue that decouples the front end from the back end.
// ============================================================================
module spp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  spp_pkg::job_t    push_job,
    output logic             full,
    input  logic             pop,
    output spp_pkg::q_head_t head
);
    import spp_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head.empty = (count_reg == '0);
    assign head.head  = mem_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && !head.empty;

    // Pointers and fill level
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: src/spp_back.sv
// ============================================================================
// SPI page program sequencer - back end
// Expands queued jobs into output words held in an output register, one
// word per cycle unless out_ready stalls that register.
// ============================================================================
module spp_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spp_pkg::q_head_t                head,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [spp_pkg::OUT_TDATA_W-1:0] out_data,
    output logic                            out_last
);
    import spp_pkg::*;

    logic [2:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    result_t    word_reg;
    logic       last_reg;
    logic       load;
    logic       final_step;
    result_t    word;

    // Index of the final word of a job
    function automatic logic [2:0] last_step(input job_kind_t kind);
        logic [2:0] n;
        case (kind)
            JOB_POLL:     n = 3'd1;
            JOB_CHUNK:    n = 3'd4;
            JOB_DATA_END: n = 3'd2;
            default:      n = 3'd0;
        endcase
        return n;
    endfunction

    // Status poll frame: opcode, then dummy byte that closes it
    function automatic result_t poll_word(input logic second);
        result_t w;
        w          = '0;
        w.tx_valid = 1'b1;
        if (second)
        begin
            w.tx_byte       = DUMMY_BYTE;
            w.frame_end     = 1'b1;
            w.expect_status = 1'b1;
        end
        else
        begin
            w.tx_byte = OP_RDSR;
        end
        return w;
    endfunction

    // Word for a given job and step
    function automatic result_t job_word(input job_t job, input logic [2:0] step);
        result_t w;
        w = '0;
        case (job.kind)
            JOB_FINISH:
            begin
                w.finished = 1'b1;
                w.success  = job.ok;
            end
            JOB_POLL:
            begin
                w = poll_word(step[0]);
            end
            JOB_CHUNK:
            begin
                w.tx_valid = 1'b1;
                case (step)
                    3'd0:
                    begin
                        w.tx_byte   = OP_WREN;
                        w.frame_end = 1'b1;
                    end
                    3'd1:    w.tx_byte = OP_PP;
                    3'd2:    w.tx_byte = job.address[23:16];
                    3'd3:    w.tx_byte = job.address[15:8];
                    default: w.tx_byte = job.address[7:0];
                endcase
            end
            JOB_DATA:
            begin
                w.tx_valid = 1'b1;
                w.tx_byte  = job.data;
            end
            JOB_DATA_END:
            begin
                if (step == 3'd0)
                begin
                    w.tx_valid  = 1'b1;
                    w.tx_byte   = job.data;
                    w.frame_end = 1'b1;
                end
                else
                begin
                    w = poll_word(step == 3'd2);
                end
            end
            default:
            begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    assign load       = !head.empty && (!valid_reg || out_ready);
    assign final_step = (step_reg == last_step(head.head.kind));
    assign word       = job_word(head.head, step_reg);
    assign pop        = load && final_step;

    // Step counter and output valid
    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            step_next  = final_step ? 3'd0 : step_reg + 3'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word;
            last_reg <= final_step;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, word_reg};
    assign out_last  = last_reg;

endmodule

FILE: src/spi_page_program_sequencer.sv
// ============================================================================
// SPI page program sequencer - top level
// Front end, job queue, back end and configuration registers.
// ============================================================================
// Each input word produces zero to five output words. The front end takes a
// word in every cycle while the four-entry job queue has room; the back end
// sends one output word per cycle from its output register unless
// m_axis_tready stalls it. A data byte or a finish yields one output word, a
// poll two, the last byte of a chunk three and a page program header five.
// The output register's one-word-per-cycle stream sets the sustained rate.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata;
// the user must write them only while the block is idle; the block itself
// does not enforce this. Index 0 is device_size, 1 protect_boundary, 2
// poll_limit, other indexes are dropped. PAGE_BYTES must be a power of two.
module spi_page_program_sequencer #(
    parameter int unsigned PAGE_BYTES = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [23:0] start_address, [48:24] byte_count, [49] allow_protected,
    // [57:50] data_byte, [65:58] status_byte, [71:66] zero
    input  logic [spp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [spp_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    // Output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] tx_byte, [8] tx_valid, [9] frame_end, [10] expect_status,
    // [11] finished, [12] success, [15:13] zero
    output logic [spp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [spp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [spp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import spp_pkg::*;

    cfg_t    cfg_reg;
    logic    q_full;
    logic    push;
    job_t    push_job;
    logic    pop;
    q_head_t head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_size      <= DEVICE_SIZE_RST;
            cfg_reg.protect_boundary <= PROTECT_BOUNDARY_RST;
            cfg_reg.poll_limit       <= POLL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DEVICE_SIZE:      cfg_reg.device_size      <= cfg_wdata;
                REG_PROTECT_BOUNDARY: cfg_reg.protect_boundary <= cfg_wdata[23:0];
                REG_POLL_LIMIT:       cfg_reg.poll_limit       <= cfg_wdata[16:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    spp_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .in_user  (s_axis_tuser),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    spp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    spp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

FILE: src/spp_checker.sv
// ============================================================================
// SPI page program sequencer - port checker
// Checks output word rules on the top-level ports; bound to the top level.
// ============================================================================
`include "spi_page_program_sequencer_defines.svh"

module spp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [spp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);
    import spp_pkg::*;

    // Output register comes up empty
    `SPP_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !m_axis_tvalid, "output valid during reset")

    // A stalled word holds
    `SPP_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output word changed")

    // Every word is either a serial byte or a completion, never both
    `SPP_ASSERT(a_byte_or_done, m_axis_tvalid |-> (m_axis_tdata[8] != m_axis_tdata[11]), "tx_valid and finished not exclusive")

    // A completion ends the response to its input word
    `SPP_ASSERT(a_done_last, m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tlast, "finished word not last")

    // A poll frame closes on the dummy byte and ends the response
    `SPP_ASSERT(a_poll_close, m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[9] && (m_axis_tdata[7:0] == DUMMY_BYTE) && m_axis_tlast, "bad status poll close")

endmodule

bind spi_page_program_sequencer spp_checker u_checker (.*);
